// ===== src/eik_pkg.sv =====
`default_nettype none

package eik_pkg;

  // Grid geometry. Cell (x, y) lives at entry y * GRID_WIDTH + x.
  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW     = $clog2(CELLS);

  // Field widths.
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 16;
  localparam int COORD_W = 8;

  // The reciprocal of speed and the square root both produce 25 bits.
  localparam int ROOT_W = 25;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  localparam logic [TIME_W-1:0] INF_TIME = '1;

  // Command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // One stored cell: frozen flag and arrival time.
  typedef struct packed {
    logic              frozen;
    logic [TIME_W-1:0] time_val;
  } cell_word_t;

  // Request to the cell store: one write or one read per cycle.
  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] addr;
    cell_word_t         wdata;
  } store_req_t;

  // Request to the shared divide and root unit.
  typedef struct packed {
    logic               start;
    logic               is_sqrt;
    logic [RAD_W-1:0]   operand;
    logic [SPEED_W-1:0] divisor;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } unit_rsp_t;

endpackage

`default_nettype wire

// ===== src/eik_cell_store.sv =====
`default_nettype none

module eik_cell_store
  import eik_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire store_req_t req,
  output cell_word_t      rd_data,
  output logic            busy
);

  cell_word_t         mem [CELLS];
  logic [CELL_AW-1:0] clr_addr;
  logic               clearing;

  // Clearing pass after reset: one entry per cycle, zero time and no frozen flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == CELL_AW'(CELLS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data <= mem[req.addr];
  end

  assign busy = clearing;

endmodule

`default_nettype wire

// ===== src/eik_root_div.sv =====
`default_nettype none

module eik_root_div
  import eik_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire unit_req_t req,
  output unit_rsp_t      rsp
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic                busy;
  logic                done;
  logic                is_sqrt;
  logic [RAD_W-1:0]    src;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   res;
  logic [SPEED_W-1:0]  divisor;
  logic [CNT_W-1:0]    cnt;

  logic [REM_W+1:0]    shifted;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    diff;
  logic                take;

  // One step: bring in the next digit, compare with the trial value, subtract.
  // Division brings in one bit against the divisor; the root brings in two
  // bits against four times the partial root plus one.
  always_comb begin
    if (is_sqrt) begin
      shifted = {rem, src[RAD_W-1 -: 2]};
      trial   = {2'b00, res, 2'b01};
    end else begin
      shifted = {1'b0, rem, src[RAD_W-1]};
      trial   = (REM_W + 2)'(divisor);
    end
    take = (shifted >= trial);
    diff = shifted - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        is_sqrt <= req.is_sqrt;
        src     <= req.operand;
        divisor <= req.divisor;
        rem     <= '0;
        res     <= '0;
      end else if (busy) begin
        rem <= take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        res <= {res[ROOT_W-2:0], take};
        src <= is_sqrt ? (src << 2) : (src << 1);
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

endmodule

`default_nettype wire

// ===== src/eikonal_first_order_update_core.sv =====
// Channel  | Direction | Handshake              | Beat contents
// -------- | --------- | ---------------------- | ---------------------------------------
// in       | input     | in_valid / in_ready    | command, cell_x, cell_y, write_time,
//          |           |                        | write_frozen, speed
// out      | output    | out_valid / out_ready  | arrival_time, used_quadratic, saturated
//
// A write, a border update or a zero speed goes from acceptance to S_DONE and the output
// register. An interior update runs the reciprocal of speed on the shared divide and root
// unit (S_CALC), the sequencer steps (side checks, two squares, discriminant), the square
// root (S_ROOT), S_DONE and the output register. It ends early in S_PREP with at most one
// side, in S_CMP with a gap over two steps and in S_DISC with a negative discriminant. The
// four neighbour reads on the single store port overlap the division.
// After reset the store runs a clearing pass over all GRID_WIDTH * GRID_HEIGHT entries
// (65536) during which no beat is accepted. One item is in work at a time; a
// finished result waits in the output register while the next beat is accepted.
`default_nettype none

module eikonal_first_order_update_core
  import eik_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               command,
  input  wire logic [COORD_W-1:0] cell_x,
  input  wire logic [COORD_W-1:0] cell_y,
  input  wire logic [TIME_W-1:0]  write_time,
  input  wire logic               write_frozen,
  input  wire logic [SPEED_W-1:0] speed,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [TIME_W-1:0]       arrival_time,
  output logic                    used_quadratic,
  output logic                    saturated
);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_PREP, S_CMP, S_MULF, S_MULD, S_DISC, S_ROOT, S_DONE
  } state_t;

  localparam int MUL_W = ROOT_W + 1;
  localparam logic [ROOT_W-1:0] DIV_ONE = ROOT_W'(1) << (ROOT_W - 1);

  state_t             state;
  logic [CELL_AW-1:0] idx;
  logic [2:0]         rd_cnt;
  logic               rd_pend;
  logic [1:0]         rd_which;
  logic [TIME_W-1:0]  t1;
  logic [TIME_W-1:0]  t2;
  logic [ROOT_W-1:0]  f_val;
  logic [TIME_W-1:0]  d_reg;
  logic [TIME_W-1:0]  lo_reg;
  logic [2*MUL_W-1:0] ff_reg;
  logic [2*MUL_W-1:0] dd_reg;
  logic [TIME_W-1:0]  res_time;
  logic               res_quad;
  logic               res_sat;

  store_req_t         store_req;
  cell_word_t         rd_data;
  logic               store_busy;
  unit_req_t          unit_req;
  unit_rsp_t          unit_rsp;

  logic               accept;
  logic               in_grid;
  logic               interior;
  logic [CELL_AW-1:0] cell_idx;
  logic [MUL_W-1:0]   mul_a;
  logic [2*MUL_W-1:0] mul_p;
  logic [2*MUL_W:0]   ff2;
  logic [2*MUL_W:0]   disc;
  logic [CELL_AW-1:0] nb_addr;

  // Saturate a widened time at infinity: returns {saturated, time}.
  function automatic logic [TIME_W:0] sat_time(input logic [TIME_W+1:0] v);
    if (v >= (TIME_W + 2)'(INF_TIME)) begin
      return {1'b1, INF_TIME};
    end
    return {1'b0, v[TIME_W-1:0]};
  endfunction

  eik_cell_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  eik_root_div u_unit (
    .clk (clk),
    .rst (rst),
    .req (unit_req),
    .rsp (unit_rsp)
  );

  // Address decode of the incoming beat.
  assign in_ready = (state == S_IDLE) && !store_busy;
  assign accept   = in_valid && in_ready;
  assign in_grid  = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
  assign interior = (cell_x != '0) && (cell_y != '0) &&
                    (32'(cell_x) + 32'd1 < GRID_WIDTH) &&
                    (32'(cell_y) + 32'd1 < GRID_HEIGHT);
  assign cell_idx = CELL_AW'(32'(cell_y) * GRID_WIDTH + 32'(cell_x));

  // Neighbour order: left, right, up, down.
  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    nb_addr = idx - 1'b1;
      2'd1:    nb_addr = idx + 1'b1;
      2'd2:    nb_addr = idx - CELL_AW'(GRID_WIDTH);
      default: nb_addr = idx + CELL_AW'(GRID_WIDTH);
    endcase
  end

  // Store port: the write of a write command, else the neighbour reads.
  always_comb begin
    store_req       = '0;
    store_req.wdata = '{frozen: write_frozen, time_val: write_time};
    if (accept && command == CMD_WRITE) begin
      store_req.we   = in_grid;
      store_req.addr = cell_idx;
    end else begin
      store_req.addr = nb_addr;
    end
  end

  // Shared unit launch: reciprocal of speed at acceptance, root after the
  // discriminant is known to be non-negative.
  assign ff2  = {ff_reg, 1'b0};
  assign disc = ff2 - (2 * MUL_W + 1)'(dd_reg);

  always_comb begin
    unit_req         = '0;
    unit_req.divisor = speed;
    if (state == S_IDLE) begin
      unit_req.start   = accept && command == CMD_UPDATE && interior && speed != '0;
      unit_req.operand = {DIV_ONE + ROOT_W'(speed[SPEED_W-1:1]), ROOT_W'(0)};
    end else if (state == S_DISC) begin
      unit_req.start   = ((2 * MUL_W + 1)'(dd_reg) <= ff2);
      unit_req.is_sqrt = 1'b1;
      unit_req.operand = disc[RAD_W-1:0];
    end
  end

  // Shared multiplier: F squared, then the difference squared.
  assign mul_a = (state == S_MULD) ? d_reg[MUL_W-1:0] : MUL_W'(f_val);
  assign mul_p = mul_a * mul_a;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_cnt    <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Neighbour reads return in the cycle after issue; keep the least frozen time per side.
      rd_pend  <= (state == S_CALC) && (rd_cnt < 3'd4);
      rd_which <= rd_cnt[1:0];
      if (state == S_CALC && rd_cnt < 3'd4) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (rd_pend && rd_data.frozen) begin
        if (!rd_which[1] && rd_data.time_val < t1) begin
          t1 <= rd_data.time_val;
        end
        if (rd_which[1] && rd_data.time_val < t2) begin
          t2 <= rd_data.time_val;
        end
      end

      // Output register.
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid      <= 1'b1;
        arrival_time   <= res_time;
        used_quadratic <= res_quad;
        saturated      <= res_sat;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= cell_idx;
            rd_cnt   <= '0;
            t1       <= INF_TIME;
            t2       <= INF_TIME;
            res_quad <= 1'b0;
            res_sat  <= 1'b0;
            res_time <= '0;
            if (command == CMD_WRITE) begin
              state <= S_DONE;
            end else if (!interior) begin
              res_time <= INF_TIME;
              state    <= S_DONE;
            end else if (speed == '0) begin
              res_time <= INF_TIME;
              res_sat  <= 1'b1;
              state    <= S_DONE;
            end else begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (unit_rsp.done) begin
            f_val <= unit_rsp.result;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // One side or both without a finite frozen neighbour.
          if (t1 == INF_TIME && t2 == INF_TIME) begin
            res_time <= INF_TIME;
            res_sat  <= 1'b1;
            state    <= S_DONE;
          end else if (t1 == INF_TIME) begin
            {res_sat, res_time} <= sat_time((TIME_W + 2)'(t2) + (TIME_W + 2)'(f_val));
            state               <= S_DONE;
          end else if (t2 == INF_TIME) begin
            {res_sat, res_time} <= sat_time((TIME_W + 2)'(t1) + (TIME_W + 2)'(f_val));
            state               <= S_DONE;
          end else begin
            d_reg  <= (t1 < t2) ? (t2 - t1) : (t1 - t2);
            lo_reg <= (t1 < t2) ? t1 : t2;
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          // A gap wider than two steps cannot meet the quadratic.
          if (d_reg > TIME_W'({f_val, 1'b0})) begin
            {res_sat, res_time} <= sat_time((TIME_W + 2)'(lo_reg) + (TIME_W + 2)'(f_val));
            state               <= S_DONE;
          end else begin
            state <= S_MULF;
          end
        end
        S_MULF: begin
          ff_reg <= mul_p;
          state  <= S_MULD;
        end
        S_MULD: begin
          dd_reg <= mul_p;
          state  <= S_DISC;
        end
        S_DISC: begin
          // Negative discriminant falls back to the one-sided step.
          if (unit_req.start) begin
            state <= S_ROOT;
          end else begin
            {res_sat, res_time} <= sat_time((TIME_W + 2)'(lo_reg) + (TIME_W + 2)'(f_val));
            state               <= S_DONE;
          end
        end
        S_ROOT: begin
          if (unit_rsp.done) begin
            {res_sat, res_time} <= sat_time(((TIME_W + 2)'(t1) + (TIME_W + 2)'(t2) +
                                             (TIME_W + 2)'(unit_rsp.result)) >> 1);
            res_quad            <= 1'b1;
            state               <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The division must outlast the four neighbour reads.
  a_reads_before_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC && unit_rsp.done) |-> (rd_cnt == 3'd4 && !rd_pend))
    else $error("neighbour reads still in flight when the reciprocal completed");

  // The shared unit is only launched from acceptance or the discriminant check.
  a_unit_start: assert property (@(posedge clk) disable iff (rst)
    unit_req.start |-> (state == S_IDLE || state == S_DISC))
    else $error("shared unit started from an unexpected state");

  // The squares are only formed when the gap is within two steps.
  a_gap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULF) |-> (d_reg <= TIME_W'({f_val, 1'b0})))
    else $error("difference exceeds the multiplier range");

  // No beat is taken while the clearing pass runs.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !in_ready)
    else $error("input accepted during the store clearing pass");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import eik_pkg::*;

  // Cycles without any accepted beat before the run is abandoned. This covers
  // the store clearing pass after reset with plenty of room to spare.
  localparam int unsigned STALL_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_BEATS  = 90;
  localparam int unsigned TOTAL_BEATS  = 950;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  t;
    logic               fz;
    logic [SPEED_W-1:0] spd;
  } cell_beat_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic              quad;
    logic              sat;
  } arrival_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic       in_valid  = 1'b0;
  logic       out_ready = 1'b0;
  cell_beat_t held_beat = '0;

  logic              in_ready;
  logic              out_valid;
  logic [TIME_W-1:0] arrival_time;
  logic              used_quadratic;
  logic              saturated;

  // Own copy of the grid: arrival time and frozen flag per cell.
  bit [TIME_W-1:0] grid_time   [CELLS];
  bit              grid_frozen [CELLS];

  cell_beat_t  pending_beats[$];
  arrival_t    arrival_expect[$];
  int unsigned beats_in    = 0;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;

  // Idling per phase: none, sender only, receiver only, both.
  int unsigned send_gap_pct   [4] = '{0, 59, 0, 28};
  int unsigned recv_stall_pct [4] = '{0, 0, 59, 28};

  eikonal_first_order_update_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (held_beat.cmd),
    .cell_x         (held_beat.x),
    .cell_y         (held_beat.y),
    .write_time     (held_beat.t),
    .write_frozen   (held_beat.fz),
    .speed          (held_beat.spd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .arrival_time   (arrival_time),
    .used_quadratic (used_quadratic),
    .saturated      (saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Integer square root, one result bit at a time from the top.
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // Least frozen finite time of a pair of cells, infinity if there is none.
  function automatic logic [TIME_W-1:0] side_least(input int a, input int b);
    logic [TIME_W-1:0] m;
    m = INF_TIME;
    if (grid_frozen[a] && grid_time[a] < m) m = grid_time[a];
    if (grid_frozen[b] && grid_time[b] < m) m = grid_time[b];
    return m;
  endfunction

  // Applies one beat to the grid copy and returns the result it must give.
  function automatic arrival_t predict_arrival(input cell_beat_t bt);
    arrival_t          r;
    int                idx;
    logic [TIME_W-1:0] th, tv, lo;
    logic [63:0]       f, d, tval;
    logic              quad;
    r = '0;
    idx = int'(bt.y) * GRID_WIDTH + int'(bt.x);
    if (bt.cmd == CMD_WRITE) begin
      if (int'(bt.x) < GRID_WIDTH && int'(bt.y) < GRID_HEIGHT) begin
        grid_time[idx]   = bt.t;
        grid_frozen[idx] = bt.fz;
      end
      return r;
    end
    // Border cells have no full neighbourhood.
    if (bt.x < 1 || bt.y < 1 || int'(bt.x) + 1 >= GRID_WIDTH ||
        int'(bt.y) + 1 >= GRID_HEIGHT) begin
      r.t = INF_TIME;
      return r;
    end
    if (bt.spd == '0) begin
      r.t   = INF_TIME;
      r.sat = 1'b1;
      return r;
    end
    th   = side_least(idx - 1, idx + 1);
    tv   = side_least(idx - GRID_WIDTH, idx + GRID_WIDTH);
    f    = ((64'd1 << 24) + 64'(bt.spd >> 1)) / 64'(bt.spd);
    quad = 1'b0;
    if (th == INF_TIME && tv == INF_TIME) begin
      tval = 64'(INF_TIME);
    end else if (th == INF_TIME) begin
      tval = 64'(tv) + f;
    end else if (tv == INF_TIME) begin
      tval = 64'(th) + f;
    end else begin
      lo = (th < tv) ? th : tv;
      d  = (th < tv) ? 64'(tv - th) : 64'(th - tv);
      if (d > 2 * f || d * d > 2 * f * f) begin
        tval = 64'(lo) + f;
      end else begin
        tval = (64'(th) + 64'(tv) + root_floor(2 * f * f - d * d)) >> 1;
        quad = 1'b1;
      end
    end
    r.quad = quad;
    if (tval >= 64'(INF_TIME)) begin
      r.t   = INF_TIME;
      r.sat = 1'b1;
    end else begin
      r.t = tval[TIME_W-1:0];
    end
    return r;
  endfunction

  task automatic push_write(input int x, input int y, input logic [TIME_W-1:0] t,
                            input logic fz);
    cell_beat_t bt;
    bt.cmd = CMD_WRITE;
    bt.x   = COORD_W'(x);
    bt.y   = COORD_W'(y);
    bt.t   = t;
    bt.fz  = fz;
    bt.spd = SPEED_W'($urandom);
    pending_beats = {pending_beats, bt};
  endtask

  task automatic push_update(input int x, input int y, input logic [SPEED_W-1:0] spd);
    cell_beat_t bt;
    bt.cmd = CMD_UPDATE;
    bt.x   = COORD_W'(x);
    bt.y   = COORD_W'(y);
    bt.t   = $urandom;
    bt.fz  = 1'($urandom);
    bt.spd = spd;
    pending_beats = {pending_beats, bt};
  endtask

  // Writes a random set of neighbours around an interior cell with times close
  // enough together to exercise both the quadratic and the fallback, then asks
  // for the update there.
  task automatic add_front_probe();
    int          cx, cy;
    int          nx[4], ny[4];
    logic [15:0] spd;
    int unsigned f, spread;
    logic [63:0] base, nt;
    cx = $urandom_range(1, GRID_WIDTH - 2);
    cy = $urandom_range(1, GRID_HEIGHT - 2);
    case ($urandom_range(0, 3))
      0: spd = SPEED_W'($urandom_range(1, 65535));
      1: spd = SPEED_W'($urandom_range(1, 255));
      default: spd = SPEED_W'($urandom_range(128, 4096));
    endcase
    f      = ((1 << 24) + (spd >> 1)) / spd;
    spread = $urandom_range(0, 1) ? f : 3 * f;
    if ($urandom_range(0, 9) == 0) base = 64'hFFFF_FFFF - $urandom_range(0, 1 << 24);
    else base = 64'($urandom);
    nx = '{cx - 1, cx + 1, cx, cx};
    ny = '{cy, cy, cy - 1, cy + 1};
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) == 0) nt = 64'hFFFF_FFFF;
        else nt = base + $urandom_range(0, spread);
        if (nt > 64'hFFFF_FFFF) nt = 64'hFFFF_FFFF;
        push_write(nx[k], ny[k], nt[31:0], $urandom_range(0, 99) < 80);
      end
    end
    push_update(cx, cy, spd);
  endtask

  task automatic flag_beat(input string why, input arrival_t want, input arrival_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: result error (%s): expected time %h quad %b sat %b, got time %h quad %b sat %b",
               why, want.t, want.quad, want.sat, got.t, got.quad, got.sat);
  endtask

  // Stimulus, run control and final verdict.
  initial begin
    // Directed beats: extremes, the border, missing neighbours, zero speed,
    // a frozen infinite neighbour, each branch of the two-sided solve and
    // saturation.
    push_write(0, 0, 32'h0000_0000, 1'b1);
    push_write(255, 255, INF_TIME, 1'b0);
    push_update(0, 10, 16'd256);
    push_update(255, 10, 16'hFFFF);
    push_update(10, 0, 16'd1);
    push_update(10, 255, 16'd256);
    push_update(40, 40, 16'd256);
    push_update(40, 40, 16'd0);
    push_write(9, 20, 32'h0001_0000, 1'b1);
    push_write(11, 20, INF_TIME, 1'b1);
    push_write(10, 19, INF_TIME, 1'b1);
    push_update(10, 20, 16'd256);
    push_write(10, 21, 32'h0001_0000, 1'b1);
    push_update(10, 20, 16'd256);
    push_write(10, 21, 32'h0002_999A, 1'b1);
    push_update(10, 20, 16'd256);
    push_write(10, 21, 32'h0005_0000, 1'b1);
    push_update(10, 20, 16'd256);
    push_write(9, 20, 32'hFFFF_FFF0, 1'b1);
    push_write(10, 21, 32'h0000_0000, 1'b0);
    push_update(10, 20, 16'd1);
    push_write(9, 20, 32'h0000_0100, 1'b1);
    push_write(10, 21, 32'h0000_0180, 1'b1);
    push_update(10, 20, 16'hFFFF);

    // Random part: mostly neighbourhood probes, the rest loose writes and
    // updates, some of them packed into a small patch so that they interact.
    while (pending_beats.size() < TOTAL_BEATS) begin
      if ($urandom_range(0, 99) < 70) begin
        add_front_probe();
      end else begin
        case ($urandom_range(0, 3))
          0: push_write($urandom_range(0, 255), $urandom_range(0, 255), $urandom,
                        1'($urandom));
          1: push_write($urandom_range(0, 9), $urandom_range(0, 9), $urandom,
                        1'($urandom));
          2: push_update($urandom_range(1, 8), $urandom_range(1, 8),
                         SPEED_W'($urandom_range(1, 65535)));
          default: push_update($urandom_range(0, 255), $urandom_range(0, 255),
                               SPEED_W'($urandom_range(1, 65535)));
        endcase
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || in_valid || arrival_expect.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && arrival_expect.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Sender: holds each beat until it is taken, then loads the next one or
  // leaves a gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        arrival_expect = {arrival_expect, predict_arrival(held_beat)};
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 &&
            $urandom_range(0, 99) >= send_gap_pct[(beats_in / PHASE_BEATS) % 4]) begin
          in_valid  <= 1'b1;
          held_beat <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and a field-by-field check of each result.
  always @(posedge clk) begin : result_check
    arrival_t want;
    arrival_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_stall_pct[(beats_in / PHASE_BEATS) % 4];
      if (out_valid && out_ready) begin
        got.t    = arrival_time;
        got.quad = used_quadratic;
        got.sat  = saturated;
        if (arrival_expect.size() == 0) begin
          flag_beat("unexpected beat", '0, got);
        end else begin
          want = arrival_expect.pop_front();
          if (got.t !== want.t || got.quad !== want.quad || got.sat !== want.sat)
            flag_beat("field mismatch", want, got);
        end
      end
    end
  end

  // Watchdog on progress of either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

endmodule
